// ----- src/rcmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcmf_pkg: shared types, constants and arithmetic helpers
// Pixel, line-store entry and handshake payload types, config codes and the
// exact divide-by-five used for the rounded five-point mean.
// ----------------------------------------------------------------------------
`default_nettype none

package rcmf_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 128;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned FW_W       = 8;   // frame_width register
  localparam int unsigned FH_W       = 13;  // frame_height register
  localparam int unsigned ROW_W      = 12;  // row counters
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd4096;
  localparam int unsigned     WIDTH_MIN        = 3;
  localparam logic [FH_W-1:0] HEIGHT_MIN       = 13'd3;
  localparam logic [FH_W-1:0] HEIGHT_MAX       = 13'd4096;

  // Output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // floor(x / 5) == (x * 1639) >> 13 for every x below 2730
  localparam int unsigned    SUM_W      = 11;
  localparam int unsigned    PROD_W     = 22;
  localparam logic [PROD_W-1:0] DIV5_MUL = 22'd1639;
  localparam int unsigned    DIV5_SHIFT = 13;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Source of the result pixel
  typedef enum logic [1:0] {
    SEL_CENTER = 2'd0,  // upper-store entry at the output column
    SEL_LOWER  = 2'd1,  // middle-store entry at the output column
    SEL_MEAN   = 2'd2   // five-point mean
  } sel_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // One line-store entry holds the same column of both stored rows
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } out_t;

  // Control handed from address stage to data stage
  typedef struct packed {
    logic   wr;       // pixel item: line-store write-back
    logic   emit;     // item produces a result
    sel_e   sel;
    logic   last;
    logic   fwd_a0;   // read hit on the previous item's write
    logic   fwd_a1;
    logic   fwd_b0;
    logic   fwd_b1;
    logic   self_a1;  // read hit on this item's own write
    logic   self_b0;
    logic   self_b1;
    pixel_t px;
  } s1_ctrl_t;

  function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * DIV5_MUL;
    return p[DIV5_SHIFT +: CH_W];
  endfunction

  function automatic logic [CH_W-1:0] mean5(input logic [CH_W-1:0] c, input logic [CH_W-1:0] u,
                                            input logic [CH_W-1:0] d, input logic [CH_W-1:0] l,
                                            input logic [CH_W-1:0] r);
    logic [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(u) + SUM_W'(d) + SUM_W'(l) + SUM_W'(r) + SUM_W'(2);
    return div5(s);
  endfunction

  function automatic pixel_t mean_pix(input pixel_t c, input pixel_t u, input pixel_t d,
                                      input pixel_t l, input pixel_t r);
    pixel_t m;
    m.red   = mean5(c.red,   u.red,   d.red,   l.red,   r.red);
    m.green = mean5(c.green, u.green, d.green, l.green, r.green);
    m.blue  = mean5(c.blue,  u.blue,  d.blue,  l.blue,  r.blue);
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/rcmf_line_ram.sv -----
// ----------------------------------------------------------------------------
// rcmf_line_ram: line-store RAM
// One write port, two read ports, registered read data (read-before-write).
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_line_ram #(
  parameter int unsigned DEPTH = rcmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  rcmf_pkg::line_t            wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b_i,
  output rcmf_pkg::line_t            rdata_a_o,
  output rcmf_pkg::line_t            rdata_b_o
);
  import rcmf_pkg::*;

  line_t mem_q [DEPTH];
  line_t rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- src/rcmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcmf_ctrl: config registers, position counters and address stage
// Decides per item whether it writes and emits, issues the four line-store
// reads and flags read hits for forwarding in the data stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_ctrl #(
  parameter int unsigned MAX_WIDTH = rcmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [rcmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rcmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                accept_i,
  input  rcmf_pkg::in_t                       in_data_i,
  output logic [$clog2(MAX_WIDTH)-1:0]        raddr_a0_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        raddr_a1_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        raddr_b0_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        raddr_b1_o,
  output rcmf_pkg::s1_ctrl_t                  s1_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        s1_waddr_o
);
  import rcmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;

  logic [FW_W-1:0]  fw_q, fw_d;
  logic [FH_W-1:0]  fh_q, fh_d;
  logic [CW-1:0]    ci_q, ci_d, co_q, co_d;
  logic [ROW_W-1:0] ri_q, ri_d, ro_q, ro_d;
  s1_ctrl_t         s1_q, s1_d;
  logic [CW-1:0]    s1_waddr_q;

  logic [WW-1:0]    w_eff, ci_inc, co_inc;
  logic [FH_W-1:0]  h_eff, ri_inc, ro_inc;
  logic             ci_wrap, co_last, ri_wrap, ro_last;
  logic             fire, at_start, pending, is_flush, emit, border;
  logic [CW-1:0]    addr_a0, addr_a1, addr_b0, addr_b1;

  // Clamped frame sizes
  always_comb begin
    priority if (fw_q < FW_W'(WIDTH_MIN)) begin
      w_eff = WW'(WIDTH_MIN);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    priority if (fh_q < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (fh_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = fh_q;
    end
  end

  assign ci_inc  = {1'b0, ci_q} + WW'(1);
  assign co_inc  = {1'b0, co_q} + WW'(1);
  assign ri_inc  = {1'b0, ri_q} + FH_W'(1);
  assign ro_inc  = {1'b0, ro_q} + FH_W'(1);
  assign ci_wrap = ci_inc >= w_eff;
  assign co_last = co_inc >= w_eff;
  assign ri_wrap = ri_inc >= h_eff;
  assign ro_last = ro_inc >= h_eff;

  assign fire     = (ri_q >= ROW_W'(2)) || ((ri_q == ROW_W'(1)) && (ci_q != '0));
  assign at_start = (ri_q == '0) && (ci_q == '0);
  assign pending  = (ro_q != '0) || (co_q != '0);
  assign is_flush = in_data_i.command == CMD_FLUSH;
  assign emit     = is_flush ? (at_start && pending) : fire;
  assign border   = (ro_q == '0) || ro_last || (co_q == '0) || co_last;

  assign addr_a0 = ci_q;
  assign addr_a1 = co_q;
  assign addr_b0 = co_q - CW'(1);
  assign addr_b1 = co_q + CW'(1);

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_d = cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_d = cfg_data_i[FH_W-1:0];
      endcase
    end
  end

  always_comb begin
    ci_d = ci_q;
    ri_d = ri_q;
    co_d = co_q;
    ro_d = ro_q;
    if (accept_i) begin
      if (!is_flush) begin
        if (ci_wrap) begin
          ci_d = '0;
          ri_d = ri_wrap ? '0 : ri_inc[ROW_W-1:0];
        end else begin
          ci_d = ci_inc[CW-1:0];
        end
      end
      if (emit) begin
        if (co_last) begin
          co_d = '0;
          ro_d = ro_last ? '0 : ro_inc[ROW_W-1:0];
        end else begin
          co_d = co_inc[CW-1:0];
        end
      end else if (!is_flush && at_start && pending) begin
        // new frame starts before the old one was flushed: drop the rest
        co_d = '0;
        ro_d = '0;
      end
    end
  end

  always_comb begin
    s1_d.wr      = accept_i && !is_flush;
    s1_d.emit    = accept_i && emit;
    if (is_flush) begin
      s1_d.sel = ro_last ? SEL_LOWER : SEL_CENTER;
    end else begin
      s1_d.sel = border ? SEL_CENTER : SEL_MEAN;
    end
    s1_d.last    = ro_last && co_last;
    s1_d.fwd_a0  = s1_q.wr && (addr_a0 == s1_waddr_q);
    s1_d.fwd_a1  = s1_q.wr && (addr_a1 == s1_waddr_q);
    s1_d.fwd_b0  = s1_q.wr && (addr_b0 == s1_waddr_q);
    s1_d.fwd_b1  = s1_q.wr && (addr_b1 == s1_waddr_q);
    s1_d.self_a1 = !is_flush && (addr_a1 == ci_q);
    s1_d.self_b0 = !is_flush && (addr_b0 == ci_q);
    s1_d.self_b1 = !is_flush && (addr_b1 == ci_q);
    s1_d.px      = '{red:   in_data_i.red_in,
                     green: in_data_i.green_in,
                     blue:  in_data_i.blue_in};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
      ci_q <= '0;
      ri_q <= '0;
      co_q <= '0;
      ro_q <= '0;
      s1_q <= '0;
    end else begin
      fw_q <= fw_d;
      fh_q <= fh_d;
      ci_q <= ci_d;
      ri_q <= ri_d;
      co_q <= co_d;
      ro_q <= ro_d;
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_waddr_q <= ci_q;
  end

  assign raddr_a0_o = addr_a0;
  assign raddr_a1_o = addr_a1;
  assign raddr_b0_o = addr_b0;
  assign raddr_b1_o = addr_b1;
  assign s1_o       = s1_q;
  assign s1_waddr_o = s1_waddr_q;

endmodule

`default_nettype wire

// ----- src/rcmf_datapath.sv -----
// ----------------------------------------------------------------------------
// rcmf_datapath: data stage
// Forwards in-flight writes onto the RAM read data, forms the write-back
// entry, keeps the upper-neighbor window and selects border copy or mean.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcmf_pkg::s1_ctrl_t  s1_i,
  input  rcmf_pkg::line_t     rd_a0_i,
  input  rcmf_pkg::line_t     rd_a1_i,
  input  rcmf_pkg::line_t     rd_b0_i,
  input  rcmf_pkg::line_t     rd_b1_i,
  output logic                we_o,
  output rcmf_pkg::line_t     wdata_o,
  output logic                item_valid_o,
  output rcmf_pkg::out_t      item_o
);
  import rcmf_pkg::*;

  line_t  fwd_q;
  pixel_t win_q, win_d;
  line_t  pre_a0, pre_a1, pre_b0, pre_b1, wd;
  line_t  post_a1, post_b0, post_b1;
  pixel_t c_pix, d_pix, l_pix, r_pix, mean, res;

  // state as the previous item left it
  assign pre_a0 = s1_i.fwd_a0 ? fwd_q : rd_a0_i;
  assign pre_a1 = s1_i.fwd_a1 ? fwd_q : rd_a1_i;
  assign pre_b0 = s1_i.fwd_b0 ? fwd_q : rd_b0_i;
  assign pre_b1 = s1_i.fwd_b1 ? fwd_q : rd_b1_i;

  // middle row moves up, new pixel enters the middle row
  assign wd.upper  = pre_a0.middle;
  assign wd.middle = s1_i.px;

  // output reads see this item's own write
  assign post_a1 = s1_i.self_a1 ? wd : pre_a1;
  assign post_b0 = s1_i.self_b0 ? wd : pre_b0;
  assign post_b1 = s1_i.self_b1 ? wd : pre_b1;

  assign c_pix = post_a1.upper;
  assign d_pix = post_a1.middle;
  assign l_pix = post_b0.upper;
  assign r_pix = post_b1.upper;
  assign mean  = mean_pix(c_pix, win_q, d_pix, l_pix, r_pix);

  always_comb begin
    unique case (s1_i.sel)
      SEL_CENTER: res = c_pix;
      SEL_LOWER:  res = d_pix;
      SEL_MEAN:   res = mean;
      default:    res = c_pix;
    endcase
  end

  assign win_d = s1_i.wr ? pre_a0.upper : win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wd;
  end

  assign we_o         = s1_i.wr;
  assign wdata_o      = wd;
  assign item_valid_o = s1_i.emit;
  assign item_o       = '{red_out:   res.red,
                          green_out: res.green,
                          blue_out:  res.blue,
                          frame_end: s1_i.last};

endmodule

`default_nettype wire

// ----- src/rcmf_out_queue.sv -----
// ----------------------------------------------------------------------------
// rcmf_out_queue: result queue
// Small register FIFO between the data stage and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_out_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  rcmf_pkg::out_t                   push_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rcmf_pkg::out_t                   out_data_o,
  output logic [rcmf_pkg::OQ_CNT_W-1:0]    count_o
);
  import rcmf_pkg::*;

  out_t                slot_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d = push_i ? wptr_q + OQ_PTR_W'(1) : wptr_q;
    rptr_d = pop ? rptr_q + OQ_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + OQ_CNT_W'(push_i) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = slot_q[rptr_q];
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

// ----- src/rgb_cross_mean_filter_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_cross_mean_filter_unit: five-point cross mean filter for RGB pixels
// Throughput: 1 item per cycle while the result queue has room, set by the
//   line-store RAM pair that is read and written back once per cycle; a
//   4-entry result queue absorbs output stalls.
// Reset: config registers, counters, window and queue clear at once; the line
//   stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_cross_mean_filter_unit #(
  parameter int unsigned MAX_WIDTH = rcmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel / flush input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcmf_pkg::in_t                     in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rcmf_pkg::out_t                    out_data_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rcmf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rcmf_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned BLG_W = OQ_CNT_W + 1;

  logic                accept;
  logic [CW-1:0]       raddr_a0, raddr_a1, raddr_b0, raddr_b1, s1_waddr;
  s1_ctrl_t            s1;
  line_t               rd_a0, rd_a1, rd_b0, rd_b1, wdata;
  logic                we;
  logic                item_valid;
  out_t                item;
  logic [OQ_CNT_W-1:0] q_count;
  logic [BLG_W-1:0]    backlog;

  // Config registers take a transfer every cycle.
  assign cfg_ready_o = 1'b1;

  // Results that will occupy the queue: queued ones plus the one in the data
  // stage. An item transferred now passes the address-stage register before it
  // lands in the queue, by which time at most one more entry has been filled,
  // so one free slot beyond the data stage is all that is needed.
  assign backlog    = BLG_W'(q_count) + BLG_W'(s1.emit);
  assign in_ready_o = backlog < BLG_W'(OQ_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  // Address stage: counters, decisions, read addresses. Its reads and the
  // data stage's write of the previous item meet at the same edge; the data
  // stage resolves that through the forwarding flags.
  rcmf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .raddr_a0_o  (raddr_a0),
    .raddr_a1_o  (raddr_a1),
    .raddr_b0_o  (raddr_b0),
    .raddr_b1_o  (raddr_b1),
    .s1_o        (s1),
    .s1_waddr_o  (s1_waddr)
  );

  // Two copies of the combined upper/middle line store, written alike.
  // Copy A reads the input column and the output column,
  // copy B the left and right neighbors of the output column.
  rcmf_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (s1_waddr),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (raddr_a0),
    .raddr_b_i (raddr_a1),
    .rdata_a_o (rd_a0),
    .rdata_b_o (rd_a1)
  );

  rcmf_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (s1_waddr),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (raddr_b0),
    .raddr_b_i (raddr_b1),
    .rdata_a_o (rd_b0),
    .rdata_b_o (rd_b1)
  );

  // Data stage: forwarding, write-back entry, border copy or mean.
  rcmf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_i         (s1),
    .rd_a0_i      (rd_a0),
    .rd_a1_i      (rd_a1),
    .rd_b0_i      (rd_b0),
    .rd_b1_i      (rd_b1),
    .we_o         (we),
    .wdata_o      (wdata),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Result queue parts the output channel from the pipeline.
  rcmf_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_valid),
    .push_data_i (item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (q_count)
  );

endmodule

`default_nettype wire

// ----- src/rcmf_checker.sv -----
// ----------------------------------------------------------------------------
// rcmf_checker: port-level assertions for the filter unit
// Watches handshakes and pipeline timing seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input rcmf_pkg::out_t                    out_data_o
);
  import rcmf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed while stalled");

  // input only backs up behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // empty queue and empty pipeline must take input
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !$past(in_valid_i && in_ready_o)) |-> in_ready_o)
    else $error("input stalled while idle");

  // a fresh result stems from an input transfer through the address and data stages
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transfer");

endmodule

bind rgb_cross_mean_filter_unit rcmf_checker u_rcmf_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for rgb_cross_mean_filter_unit
// Streams RGB frames through the filter and checks each result transfer,
// in order, against a cycle-free model of the line stores and raster
// counters. It opens with a table of hand-picked items, then runs random
// frames over several frame sizes, the clamped extremes among them. Both
// handshake sides idle at random, apart from one long stretch without gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcmf_pkg::*;

  localparam int unsigned LINE_LEN      = DEF_MAX_WIDTH;
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES = 8;     // address and data stages plus 4-deep queue
  localparam int unsigned STALL_PCT     = 14;
  localparam int unsigned DIR_LEN       = 26;

  // How a table row states its expectation
  typedef enum logic [1:0] {
    EXP_NONE,   // no result
    EXP_TYPED,  // result typed into the table
    EXP_MODEL   // result taken from the filter model
  } exp_kind_e;

  typedef struct {
    in_t       item;
    exp_kind_e kind;
    out_t      result;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rgb_cross_mean_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Filter model state: two stored rows, the upper-neighbor window, input and
  // output raster positions and the two size registers.
  // --------------------------------------------------------------------------
  pixel_t          upper_row  [LINE_LEN];
  pixel_t          middle_row [LINE_LEN];
  pixel_t          win_near = '0;
  int unsigned     in_row   = 0;
  int unsigned     in_col   = 0;
  int unsigned     out_row  = 0;
  int unsigned     out_col  = 0;
  logic [FW_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [FH_W-1:0] height_reg = FRAME_HEIGHT_RST;

  out_t        pending_results [$];  // results still owed by the block, oldest first
  int unsigned errors     = 0;
  int unsigned items_sent = 0;
  bit          steady     = 1'b0;    // no idling on either side while set
  int unsigned idle_cycles = 0;

  dir_row_t    dir_tab [DIR_LEN];

  // Sizes as the block uses them: registers clamped to their legal ranges
  function automatic int unsigned line_width();
    int unsigned w;
    w = width_reg;
    if (w < WIDTH_MIN) w = WIDTH_MIN;
    if (w > LINE_LEN) w = LINE_LEN;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = height_reg;
    if (h < HEIGHT_MIN) h = HEIGHT_MIN;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  // Rounded mean of five 8-bit samples, exact integer form
  function automatic logic [CH_W-1:0] chan_mean(input int unsigned a, input int unsigned b,
                                                input int unsigned c, input int unsigned d,
                                                input int unsigned e);
    return CH_W'((a + b + c + d + e + 2) / 5);
  endfunction

  function automatic pixel_t cross_mean(input pixel_t c, input pixel_t u, input pixel_t d,
                                        input pixel_t l, input pixel_t r);
    pixel_t m;
    m.red   = chan_mean(c.red,   u.red,   d.red,   l.red,   r.red);
    m.green = chan_mean(c.green, u.green, d.green, l.green, r.green);
    m.blue  = chan_mean(c.blue,  u.blue,  d.blue,  l.blue,  r.blue);
    return m;
  endfunction

  // Builds the result at the output position, then steps that position
  function automatic out_t emit_pixel(input pixel_t px, input int unsigned w,
                                      input int unsigned h);
    out_t o;
    o.red_out   = px.red;
    o.green_out = px.green;
    o.blue_out  = px.blue;
    o.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    return o;
  endfunction

  // One accepted item through the model; returns 1 when it causes a result
  function automatic bit filter_step(input in_t it, output out_t res);
    int unsigned w, h, ci, ri, co;
    bit          at_start, pending, fire;
    pixel_t      px, up, ctr;
    w        = line_width();
    h        = frame_rows();
    res      = '0;
    at_start = (in_row == 0) && (in_col == 0);
    pending  = (out_row != 0) || (out_col != 0);

    if (it.command == CMD_FLUSH) begin
      // only drains a finished frame; ignored mid-frame and when all is out
      if (!at_start || !pending) return 1'b0;
      co  = (out_col < LINE_LEN) ? out_col : LINE_LEN - 1;
      res = emit_pixel((out_row + 1 >= h) ? middle_row[co] : upper_row[co], w, h);
      return 1'b1;
    end

    px = {it.red_in, it.green_in, it.blue_in};
    ci = (in_col < LINE_LEN) ? in_col : LINE_LEN - 1;
    ri = in_row;
    // a new frame while the old one drains drops what is left of it
    if (at_start && pending) begin
      out_row = 0;
      out_col = 0;
    end
    up             = win_near;
    win_near       = upper_row[ci];
    upper_row[ci]  = middle_row[ci];
    middle_row[ci] = px;

    // the first W+1 pixels of a frame only fill the pipeline
    fire   = (ri >= 2) || (ri == 1 && ci >= 1);
    in_col = ci + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = ri + 1;
      if (in_row >= h) in_row = 0;
    end
    if (!fire) return 1'b0;

    co  = (out_col < LINE_LEN) ? out_col : LINE_LEN - 1;
    ctr = upper_row[co];
    if (out_row == 0 || out_row + 1 >= h || co == 0 || co + 1 >= w) begin
      res = emit_pixel(ctr, w, h);  // border pixel passes through
    end else begin
      res = emit_pixel(cross_mean(ctr, up, middle_row[co], upper_row[co - 1],
                                  upper_row[co + 1]), w, h);
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t row_of(input cmd_e cmd, input logic [23:0] rgb,
                                      input exp_kind_e kind, input logic [23:0] want = '0,
                                      input logic want_end = 1'b0);
    dir_row_t r;
    r.item   = {cmd, rgb};
    r.kind   = kind;
    r.result = {want, want_end};
    return r;
  endfunction

  // Channel value, biased toward the two extremes
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(9) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return CH_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Called at a falling edge; may idle first, then holds the
  // item until its transfer and runs it through the model at that edge.
  // Returns at the next falling edge without touching valid.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_t it, output bit fired, output out_t res);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fired = filter_step(it, res);
    items_sent++;
    steady = (items_sent >= 450) && (items_sent < 700);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
    else height_reg = value[FH_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sender holds off until every owed result has come back, then lets
  // ignored items still in the pipe run out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sizes change only with the block idle and both raster positions at zero.
  // Width data carries random bits above the 8-bit register.
  task automatic resize(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h);
    logic [CFG_DATA_W-FW_W-1:0] pad;
    pad = (CFG_DATA_W-FW_W)'($urandom);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, {pad, w});
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Random frames. Mostly well-formed: full frames, then flushes for the
  // pending outputs. Mixed in: flushes mid-frame (ignored), flushes with
  // nothing pending, and new frames cutting a drain short. With close_frame
  // the phase ends on a clean frame boundary; otherwise it may stop anywhere.
  // --------------------------------------------------------------------------
  task automatic run_phase(input int unsigned budget, input bit close_frame);
    int unsigned pixels;
    bit          clean, fired;
    in_t         it;
    out_t        res;
    pixels = 0;
    forever begin
      clean = (in_row == 0) && (in_col == 0) && (out_row == 0) && (out_col == 0);
      if (pixels >= budget && (clean || !close_frame)) break;
      it.command  = CMD_PIXEL;
      it.red_in   = pick_channel();
      it.green_in = pick_channel();
      it.blue_in  = pick_channel();
      if (in_row != 0 || in_col != 0) begin
        if ($urandom_range(99) < 4) it.command = CMD_FLUSH;
      end else if (out_row != 0 || out_col != 0) begin
        // about one drain in ten is cut short by the next frame
        if (pixels >= budget || $urandom_range(10 * line_width()) != 0)
          it.command = CMD_FLUSH;
      end else if ($urandom_range(99) < 3) begin
        it.command = CMD_FLUSH;
      end
      send_item(it, fired, res);
      if (fired) pending_results.push_back(res);
      if (it.command == CMD_PIXEL) pixels++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, receiver stalls, result checker and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // Each result transfer is matched against the oldest owed result
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing owed", out_data_o.red_out, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.red_out !== want.red_out)
          report_mismatch("red_out", out_data_o.red_out, want.red_out);
        if (out_data_o.green_out !== want.green_out)
          report_mismatch("green_out", out_data_o.green_out, want.green_out);
        if (out_data_o.blue_out !== want.blue_out)
          report_mismatch("blue_out", out_data_o.blue_out, want.blue_out);
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", 8'(out_data_o.frame_end), 8'(want.frame_end));
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit   fired;
    out_t res;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    for (int i = 0; i < LINE_LEN; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end

    // Directed part on a 3x3 frame. Frame one: all border outputs are copies;
    // only the center is a mean. Frame two: all pixels at red and blue full
    // scale, green zero, so the center mean hits the largest and smallest
    // sums. A pixel after one flush starts frame three.
    dir_tab = '{
      row_of(CMD_FLUSH, 24'h000000, EXP_NONE),               // idle flush after reset
      row_of(CMD_PIXEL, 24'h000000, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFFFFFF, EXP_NONE),
      row_of(CMD_FLUSH, 24'hA5A5A5, EXP_NONE),               // flush mid-frame
      row_of(CMD_PIXEL, 24'h123456, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFF0080, EXP_NONE),               // last pipeline fill
      row_of(CMD_PIXEL, 24'hFF0001, EXP_TYPED, 24'h000000),
      row_of(CMD_PIXEL, 24'hFF0001, EXP_TYPED, 24'hFFFFFF),
      row_of(CMD_PIXEL, 24'h9ABCDE, EXP_TYPED, 24'h123456),
      row_of(CMD_PIXEL, 24'h00FF7F, EXP_TYPED, 24'hFF0080),
      row_of(CMD_PIXEL, 24'hABCDEF, EXP_MODEL),              // center: five-point mean
      row_of(CMD_FLUSH, 24'h000000, EXP_TYPED, 24'hFF0001),
      row_of(CMD_FLUSH, 24'hFFFFFF, EXP_TYPED, 24'h9ABCDE),
      row_of(CMD_FLUSH, 24'h000000, EXP_TYPED, 24'h00FF7F),
      row_of(CMD_FLUSH, 24'h000000, EXP_TYPED, 24'hABCDEF, 1'b1),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_NONE),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_TYPED, 24'hFF00FF),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_TYPED, 24'hFF00FF),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_TYPED, 24'hFF00FF),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_TYPED, 24'hFF00FF),
      row_of(CMD_PIXEL, 24'hFF00FF, EXP_TYPED, 24'hFF00FF),  // center mean
      row_of(CMD_FLUSH, 24'h000000, EXP_TYPED, 24'hFF00FF),
      row_of(CMD_PIXEL, 24'h000000, EXP_NONE)                // new frame drops the rest
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Both registers below their minimum: clamps to 3x3
    resize(8'd0, 13'd2);

    for (int i = 0; i < DIR_LEN; i++) begin
      send_item(dir_tab[i].item, fired, res);
      if (fired != (dir_tab[i].kind != EXP_NONE))
        report_mismatch($sformatf("table row %0d result count", i), 8'(fired),
                        8'(dir_tab[i].kind != EXP_NONE));
      if (fired)
        pending_results.push_back((dir_tab[i].kind == EXP_TYPED) ? dir_tab[i].result : res);
    end

    // Random frames: finish the 3x3 frame already begun, then small random
    // sizes, full width, small sizes again, and last the clamped maximum of
    // both registers, left unfinished.
    run_phase(80, 1'b1);
    resize(FW_W'($urandom_range(12)), FH_W'($urandom_range(8)));
    run_phase(120, 1'b1);
    resize(8'd128, 13'd3);
    run_phase(1, 1'b1);
    resize(FW_W'($urandom_range(12)), FH_W'($urandom_range(8)));
    run_phase(100, 1'b1);
    resize(8'd255, 13'd8191);
    run_phase(200, 1'b0);

    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- rgb_cross_mean_filter_unit.f -----
src/rcmf_pkg.sv
src/rcmf_line_ram.sv
src/rcmf_ctrl.sv
src/rcmf_datapath.sv
src/rcmf_out_queue.sv
src/rgb_cross_mean_filter_unit.sv
src/rcmf_checker.sv
bench/tb_top.sv
